### hw/rtl/sip_pkg.sv
package sip_pkg;

   localparam int COORD_BITS   = 16;
   localparam int TAG_BITS     = 12;
   localparam int FRAC_BITS_DEF = 16;
   localparam int POINT_BITS   = 32;

   typedef struct packed {
      logic [COORD_BITS-1:0] a_start_x;
      logic [COORD_BITS-1:0] a_start_y;
      logic [COORD_BITS-1:0] a_end_x;
      logic [COORD_BITS-1:0] a_end_y;
      logic [COORD_BITS-1:0] b_start_x;
      logic [COORD_BITS-1:0] b_start_y;
      logic [COORD_BITS-1:0] b_end_x;
      logic [COORD_BITS-1:0] b_end_y;
      logic [TAG_BITS-1:0]   seg_a_tag;
      logic [TAG_BITS-1:0]   seg_b_tag;
   } req_item_type;

   typedef struct packed {
      logic                  crossing;
      logic [POINT_BITS-1:0] cross_x;
      logic [POINT_BITS-1:0] cross_y;
      logic [TAG_BITS-1:0]   out_a_tag;
      logic [TAG_BITS-1:0]   out_b_tag;
   } rsp_item_type;

endpackage

### hw/rtl/segment_intersection_point_unit.sv
// Segment intersection point unit. Each transfer on the request side carries
// two segments and their tags; exactly one result comes back for each, in
// order. A new request can be started on every cycle and busy stays low, so
// the sustained rate is one pair per clock. The result is shown for a single
// cycle with rsp_valid high and the receiver cannot hold it off: it must take
// every result on the cycle it appears. A result reports crossing only when
// the segments cross strictly inside both of them; the point is then given in
// unsigned fixed point with FRAC_BITS fraction bits, rounded down, and it is
// zero otherwise. Tags are always copied through. The divider produces one
// quotient bit per pipeline stage.
module segment_intersection_point_unit #(
   parameter int FRAC_BITS = sip_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sip_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   output sip_pkg::rsp_item_type rsp_data
);
   import sip_pkg::*;

   localparam int CW  = COORD_BITS;
   localparam int SW  = CW + 1;        // signed coordinate difference
   localparam int PW  = 2 * CW + 2;    // signed product of two differences
   localparam int XW  = 2 * CW + 3;    // signed determinant and numerators
   localparam int DW  = 2 * CW + 1;    // magnitude of the determinant
   localparam int NW  = 3 * CW + 1;    // blended numerator
   localparam int QW  = CW + FRAC_BITS;
   localparam int SDW = 1 + 2 * TAG_BITS;

   // The pipeline never stalls, so a request is always taken.
   assign busy = 1'b0;

   // Stage 1: differences d1 = Q1-P1, d2 = Q2-P2 and w = P2-P1.
   logic                 v1_ff;
   logic signed [SW-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff, wx_ff, wy_ff;
   logic [CW-1:0]        p1x_ff [1:4];
   logic [CW-1:0]        p1y_ff [1:4];
   logic [CW-1:0]        q1x_ff [1:4];
   logic [CW-1:0]        q1y_ff [1:4];
   logic [TAG_BITS-1:0]  ta_ff [1:6];
   logic [TAG_BITS-1:0]  tb_ff [1:6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      d1x_ff <= $signed({1'b0, req_data.a_end_x}) - $signed({1'b0, req_data.a_start_x});
      d1y_ff <= $signed({1'b0, req_data.a_end_y}) - $signed({1'b0, req_data.a_start_y});
      d2x_ff <= $signed({1'b0, req_data.b_end_x}) - $signed({1'b0, req_data.b_start_x});
      d2y_ff <= $signed({1'b0, req_data.b_end_y}) - $signed({1'b0, req_data.b_start_y});
      wx_ff  <= $signed({1'b0, req_data.b_start_x}) - $signed({1'b0, req_data.a_start_x});
      wy_ff  <= $signed({1'b0, req_data.b_start_y}) - $signed({1'b0, req_data.a_start_y});
      p1x_ff[1] <= req_data.a_start_x;
      p1y_ff[1] <= req_data.a_start_y;
      q1x_ff[1] <= req_data.a_end_x;
      q1y_ff[1] <= req_data.a_end_y;
      ta_ff[1]  <= req_data.seg_a_tag;
      tb_ff[1]  <= req_data.seg_b_tag;
   end

   // The end points and tags ride alongside the arithmetic stages.
   always_ff @(posedge clock) begin
      for (int k = 2; k <= 4; k++) begin
         p1x_ff[k] <= p1x_ff[k-1];
         p1y_ff[k] <= p1y_ff[k-1];
         q1x_ff[k] <= q1x_ff[k-1];
         q1y_ff[k] <= q1y_ff[k-1];
      end
      for (int k = 2; k <= 6; k++) begin
         ta_ff[k] <= ta_ff[k-1];
         tb_ff[k] <= tb_ff[k-1];
      end
   end

   // Stage 2: the six cross-product terms, one narrow multiplier each.
   logic                 v2_ff;
   logic signed [PW-1:0] m_d1x_d2y_ff, m_d1y_d2x_ff;
   logic signed [PW-1:0] m_wx_d2y_ff, m_wy_d2x_ff;
   logic signed [PW-1:0] m_wx_d1y_ff, m_wy_d1x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      m_d1x_d2y_ff <= PW'(d1x_ff * d2y_ff);
      m_d1y_d2x_ff <= PW'(d1y_ff * d2x_ff);
      m_wx_d2y_ff  <= PW'(wx_ff * d2y_ff);
      m_wy_d2x_ff  <= PW'(wy_ff * d2x_ff);
      m_wx_d1y_ff  <= PW'(wx_ff * d1y_ff);
      m_wy_d1x_ff  <= PW'(wy_ff * d1x_ff);
   end

   // Stage 3: determinant D = d1 x d2 and numerators S = w x d2, T = w x d1.
   logic                 v3_ff;
   logic signed [XW-1:0] det_ff, sn_ff, tn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      det_ff <= XW'(m_d1x_d2y_ff) - XW'(m_d1y_d2x_ff);
      sn_ff  <= XW'(m_wx_d2y_ff) - XW'(m_wy_d2x_ff);
      tn_ff  <= XW'(m_wx_d1y_ff) - XW'(m_wy_d1x_ff);
   end

   // Stage 4: flip all three signs when D is negative, then test 0<s<1 and
   // 0<t<1 as 0 < S < D and 0 < T < D. A zero determinant (parallel or
   // degenerate segments) fails the tests on its own.
   logic                 v4_ff;
   logic                 hit4_ff;
   logic [DW-1:0]        ud_ff, us_ff, ur_ff;
   logic signed [XW-1:0] det_in, sn_in, tn_in;
   logic                 hit_in;

   always_comb begin
      if (det_ff < 0) begin
         det_in = -det_ff;
         sn_in  = -sn_ff;
         tn_in  = -tn_ff;
      end else begin
         det_in = det_ff;
         sn_in  = sn_ff;
         tn_in  = tn_ff;
      end
      hit_in = (sn_in > 0) && (sn_in < det_in) && (tn_in > 0) && (tn_in < det_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      hit4_ff <= hit_in;
      ud_ff   <= DW'(det_in);
      us_ff   <= DW'(sn_in);
      ur_ff   <= DW'(det_in - sn_in);
   end

   // Stage 5: the point is (P1*(D-S) + Q1*S) / D per axis; form the terms.
   logic          v5_ff;
   logic          hit5_ff;
   logic [DW-1:0] ud5_ff;
   logic [NW-1:0] mxa_ff, mxb_ff, mya_ff, myb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      hit5_ff <= hit4_ff;
      ud5_ff  <= ud_ff;
      mxa_ff  <= NW'(p1x_ff[4] * ur_ff);
      mxb_ff  <= NW'(q1x_ff[4] * us_ff);
      mya_ff  <= NW'(p1y_ff[4] * ur_ff);
      myb_ff  <= NW'(q1y_ff[4] * us_ff);
   end

   // Stage 6: sum the weighted end points. The sum stays below D * 2^CW
   // because the point lies between P1 and Q1.
   logic          v6_ff;
   logic          hit6_ff;
   logic [DW-1:0] ud6_ff;
   logic [NW-1:0] numx_ff, numy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      hit6_ff <= hit5_ff;
      ud6_ff  <= ud5_ff;
      numx_ff <= mxa_ff + mxb_ff;
      numy_ff <= mya_ff + myb_ff;
   end

   // Two bit-per-stage dividers, one per axis; each lane also carries the
   // hit flag and the tags so that they stay aligned with the quotient.
   logic           dvx_valid, dvy_valid;
   logic [QW-1:0]  quox, quoy;
   logic [SDW-1:0] side_x, side_y;

   sip_divider #(
      .NUM_W(NW), .DEN_W(DW), .SHIFT_W(CW), .FRAC_W(FRAC_BITS), .SIDE_W(SDW)
   ) u_div_x (
      .clock(clock), .reset(reset),
      .in_valid(v6_ff), .in_num(numx_ff), .in_den(ud6_ff),
      .in_side({hit6_ff, ta_ff[6], tb_ff[6]}),
      .out_valid(dvx_valid), .out_quo(quox), .out_side(side_x)
   );

   sip_divider #(
      .NUM_W(NW), .DEN_W(DW), .SHIFT_W(CW), .FRAC_W(FRAC_BITS), .SIDE_W(SDW)
   ) u_div_y (
      .clock(clock), .reset(reset),
      .in_valid(v6_ff), .in_num(numy_ff), .in_den(ud6_ff),
      .in_side({hit6_ff, ta_ff[6], tb_ff[6]}),
      .out_valid(dvy_valid), .out_quo(quoy), .out_side(side_y)
   );

   // Fit the quotients into the 32-bit point fields, saturating to all ones
   // when wide settings let the point overflow.
   logic [POINT_BITS-1:0] px_in, py_in;

   if (QW > POINT_BITS) begin : g_sat
      always_comb begin
         px_in = (|quox[QW-1:POINT_BITS]) ? '1 : quox[POINT_BITS-1:0];
         py_in = (|quoy[QW-1:POINT_BITS]) ? '1 : quoy[POINT_BITS-1:0];
      end
   end else begin : g_fit
      always_comb begin
         px_in = POINT_BITS'(quox);
         py_in = POINT_BITS'(quoy);
      end
   end

   // Output register; a miss gives a zero point.
   logic         rsp_valid_ff;
   rsp_item_type rsp_data_ff;
   logic         hit_out;

   assign hit_out = side_x[SDW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dvx_valid & dvy_valid;
      end
      rsp_data_ff.crossing  <= hit_out;
      rsp_data_ff.cross_x   <= hit_out ? px_in : '0;
      rsp_data_ff.cross_y   <= hit_out ? py_in : '0;
      rsp_data_ff.out_a_tag <= side_x[2*TAG_BITS-1:TAG_BITS];
      rsp_data_ff.out_b_tag <= side_y[TAG_BITS-1:0];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hw/rtl/sip_divider.sv
module sip_divider #(
   parameter int NUM_W   = 49,
   parameter int DEN_W   = 33,
   parameter int SHIFT_W = 16,
   parameter int FRAC_W  = 16,
   parameter int SIDE_W  = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [NUM_W-1:0]           in_num,
   input  logic [DEN_W-1:0]           in_den,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [SHIFT_W+FRAC_W-1:0]  out_quo,
   output logic [SIDE_W-1:0]          out_side
);
   // Restoring division, one quotient bit per stage. The dividend is
   // num * 2^FRAC_W and its quotient is known to fit in QW bits, so the
   // starting remainder is num >> SHIFT_W and only QW bits are shifted in.
   localparam int QW = SHIFT_W + FRAC_W;

   logic [DEN_W-1:0]  rem_ff  [0:QW];
   logic [DEN_W-1:0]  den_ff  [0:QW];
   logic [QW-1:0]     work_ff [0:QW];
   logic [SIDE_W-1:0] side_ff [0:QW];
   logic              valid_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
      rem_ff[0]  <= DEN_W'(in_num[NUM_W-1:SHIFT_W]);
      den_ff[0]  <= in_den;
      work_ff[0] <= QW'(in_num[SHIFT_W-1:0]) << FRAC_W;
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DEN_W:0] trial_in;
      logic [DEN_W:0] diff_in;
      logic           take_in;

      always_comb begin
         trial_in = {rem_ff[k], work_ff[k][QW-1]};
         diff_in  = trial_in - {1'b0, den_ff[k]};
         take_in  = trial_in >= {1'b0, den_ff[k]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
         rem_ff[k+1]  <= take_in ? diff_in[DEN_W-1:0] : trial_in[DEN_W-1:0];
         den_ff[k+1]  <= den_ff[k];
         work_ff[k+1] <= {work_ff[k][QW-2:0], take_in};
         side_ff[k+1] <= side_ff[k];
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quo   = work_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

### hw/rtl/sip_checker.sv
module sip_checker #(
   parameter int FRAC_BITS = sip_pkg::FRAC_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input sip_pkg::req_item_type req_data,
   input logic                  rsp_valid,
   input sip_pkg::rsp_item_type rsp_data
);
   import sip_pkg::*;

   localparam int LAT = COORD_BITS + FRAC_BITS + 8;

   // A result only ever follows an accepted request by the fixed latency.
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching request");

   a_tag_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_a_tag == $past(req_data.seg_a_tag, LAT))
      else $error("first tag out of step");

   a_tag_b: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_b_tag == $past(req_data.seg_b_tag, LAT))
      else $error("second tag out of step");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.crossing) |-> (rsp_data.cross_x == 0 && rsp_data.cross_y == 0))
      else $error("nonzero point on a miss");

endmodule

bind segment_intersection_point_unit sip_checker #(.FRAC_BITS(FRAC_BITS)) u_sip_checker (.*);

### tb/tb_segment_intersection_point_unit.sv
module tb_segment_intersection_point_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import sip_pkg::*;

   // Pipeline latency, and a drain limit that allows generous slack.
   localparam int LATENCY     = COORD_BITS + FRAC_BITS_DEF + 8;
   localparam int DRAIN_LIMIT = 4 * LATENCY + 20;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 850;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_data = '0;
   logic         rsp_valid;
   rsp_item_type rsp_data;

   segment_intersection_point_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Items waiting to be driven, and the results still owed by the block.
   req_item_type pending_pairs[$];
   rsp_item_type owed_points[$];
   int           idle_percent = 0;
   int           quiet_cycles = 0;
   bit           failed = 1'b0;
   bit           all_sent = 1'b0;

   // Predicts one result. The determinant is made positive by flipping the signs of
   // all three cross products, so the strict-inside test is 0 < S < D and 0 < T < D.
   // The point is (P*(D-S) + Q*S) * 2^16 / D, rounded down.
   function automatic rsp_item_type predict_crossing(req_item_type p);
      rsp_item_type r;
      longint d1x, d1y, d2x, d2y, wx, wy, det, sn, tn;
      logic [127:0] nx, ny;
      r = '0;
      d1x = longint'(p.a_end_x) - longint'(p.a_start_x);
      d1y = longint'(p.a_end_y) - longint'(p.a_start_y);
      d2x = longint'(p.b_end_x) - longint'(p.b_start_x);
      d2y = longint'(p.b_end_y) - longint'(p.b_start_y);
      wx  = longint'(p.b_start_x) - longint'(p.a_start_x);
      wy  = longint'(p.b_start_y) - longint'(p.a_start_y);
      det = d1x * d2y - d1y * d2x;
      sn  = wx * d2y - wy * d2x;
      tn  = wx * d1y - wy * d1x;
      if (det < 0) begin
         det = -det;
         sn  = -sn;
         tn  = -tn;
      end
      if (det != 0 && sn > 0 && sn < det && tn > 0 && tn < det) begin
         nx = (128'(p.a_start_x) * 128'(det - sn) + 128'(p.a_end_x) * 128'(sn))
              << FRAC_BITS_DEF;
         ny = (128'(p.a_start_y) * 128'(det - sn) + 128'(p.a_end_y) * 128'(sn))
              << FRAC_BITS_DEF;
         nx = nx / 128'(det);
         ny = ny / 128'(det);
         r.crossing = 1'b1;
         r.cross_x  = (nx > 128'hFFFF_FFFF) ? '1 : nx[31:0];
         r.cross_y  = (ny > 128'hFFFF_FFFF) ? '1 : ny[31:0];
      end
      r.out_a_tag = p.seg_a_tag;
      r.out_b_tag = p.seg_b_tag;
      return r;
   endfunction

   // Driver: start stays high across back-to-back transfers; the next item is
   // presented on the same edge that accepts the current one.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            owed_points.push_back(predict_crossing(req_data));
         end
         if (!start || !busy) begin
            if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_percent) begin
               start    <= 1'b1;
               req_data <= pending_pairs.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (owed_points.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               failed = 1'b1;
            end else begin
               want = owed_points.pop_front();
               if (rsp_data.crossing !== want.crossing) begin
                  $display("%0t: crossing expected %0d actual %0d", $time,
                           want.crossing, rsp_data.crossing);
                  failed = 1'b1;
               end
               if (rsp_data.cross_x !== want.cross_x) begin
                  $display("%0t: cross_x expected %h actual %h", $time,
                           want.cross_x, rsp_data.cross_x);
                  failed = 1'b1;
               end
               if (rsp_data.cross_y !== want.cross_y) begin
                  $display("%0t: cross_y expected %h actual %h", $time,
                           want.cross_y, rsp_data.cross_y);
                  failed = 1'b1;
               end
               if (rsp_data.out_a_tag !== want.out_a_tag) begin
                  $display("%0t: out_a_tag expected %h actual %h", $time,
                           want.out_a_tag, rsp_data.out_a_tag);
                  failed = 1'b1;
               end
               if (rsp_data.out_b_tag !== want.out_b_tag) begin
                  $display("%0t: out_b_tag expected %h actual %h", $time,
                           want.out_b_tag, rsp_data.out_b_tag);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   // Watchdog: too long without any transfer in either direction ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic req_item_type make_pair(int x1, int y1, int x2, int y2,
                                              int x3, int y3, int x4, int y4);
      req_item_type p;
      p.a_start_x = x1[15:0];
      p.a_start_y = y1[15:0];
      p.a_end_x   = x2[15:0];
      p.a_end_y   = y2[15:0];
      p.b_start_x = x3[15:0];
      p.b_start_y = y3[15:0];
      p.b_end_x   = x4[15:0];
      p.b_end_y   = y4[15:0];
      p.seg_a_tag = 12'($urandom);
      p.seg_b_tag = 12'($urandom);
      return p;
   endfunction

   // Random pair; most are built around a chosen point, with one segment running from
   // below left to above right of it and the other from below right to above left.
   function automatic req_item_type random_pair();
      req_item_type p;
      int cx, cy, span, k;
      k = $urandom_range(99);
      if (k < 25) begin
         p = req_item_type'($bits(req_item_type)'({$urandom, $urandom, $urandom,
                                                    $urandom, $urandom}));
      end else if (k < 35) begin
         // Small grid: collinear, touching and parallel cases become common.
         p = make_pair($urandom_range(7), $urandom_range(7), $urandom_range(7),
                       $urandom_range(7), $urandom_range(7), $urandom_range(7),
                       $urandom_range(7), $urandom_range(7));
      end else begin
         span = (k < 60) ? 255 : 32767;
         cx = $urandom_range(65535 - span, span);
         cy = $urandom_range(65535 - span, span);
         if (k >= 60) begin
            cx = $urandom_range(65535 - span, 0) + span / 2;
            cy = $urandom_range(65535 - span, 0) + span / 2;
         end
         p = make_pair(clip(cx - $urandom_range(span / 2)), clip(cy - $urandom_range(span / 2)),
                       clip(cx + $urandom_range(span / 2)), clip(cy + $urandom_range(span / 2)),
                       clip(cx + $urandom_range(span / 2)), clip(cy - $urandom_range(span / 2)),
                       clip(cx - $urandom_range(span / 2)), clip(cy + $urandom_range(span / 2)));
      end
      return p;
   endfunction

   function automatic int clip(int v);
      return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
   endfunction

   task automatic wait_drained();
      while (pending_pairs.size() > 0 || start || owed_points.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int phase;
      int n;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: proper crossing, the full-range diagonals, parallel,
      // collinear overlap, touching at an end point, T junction, zero length,
      // and maximum tags.
      pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
      pending_pairs.push_back(make_pair(0, 0, 65535, 65535, 0, 65535, 65535, 0));
      pending_pairs.push_back(make_pair(65535, 0, 0, 65535, 0, 0, 65535, 65535));
      pending_pairs.push_back(make_pair(0, 0, 65535, 1, 0, 1, 65535, 0));
      pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
      pending_pairs.push_back(make_pair(0, 0, 10, 10, 5, 5, 20, 20));
      pending_pairs.push_back(make_pair(0, 0, 10, 10, 10, 10, 20, 0));
      pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 10));
      pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(65535, 65535, 65535, 65535, 65535, 65535,
                                        65535, 65535));
      pending_pairs.push_back(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
      pending_pairs.push_back(make_pair(1, 0, 0, 7, 0, 2, 9, 3));
      pending_pairs.push_back(make_pair(0, 1, 65535, 2, 1, 0, 2, 65535));
      for (int i = 0; i < 4; i++) begin
         pending_pairs.push_back(make_pair(0, 0, 65535, 65535, 0, 65535, 65535, 0));
         pending_pairs[$].seg_a_tag = (i[0]) ? 12'hFFF : 12'h000;
         pending_pairs[$].seg_b_tag = (i[1]) ? 12'hFFF : 12'h000;
      end
      wait_drained();

      // Random traffic in phases of sender idling: none, heavy, light and none again.
      for (phase = 0; phase < 4; phase++) begin
         idle_percent = (phase == 1) ? 74 : (phase == 2) ? 9 : 0;
         n = RANDOM_ITEMS / 4;
         for (int i = 0; i < n; i++)
            pending_pairs.push_back(random_pair());
         wait_drained();
      end
      all_sent = 1'b1;

      repeat (DRAIN_LIMIT) @(posedge clock);
      if (!failed && owed_points.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/sip_pkg.sv
hw/rtl/sip_divider.sv
hw/rtl/segment_intersection_point_unit.sv
hw/rtl/sip_checker.sv
tb/tb_segment_intersection_point_unit.sv
